### sv/lbpc_pkg.sv
// ----------------------------------------------------------------------------
// lbpc_pkg: shared types and constants for the LED blink pattern classifier
// Item and result structs, pattern codes, register indexes, reset values.
// ----------------------------------------------------------------------------
package lbpc_pkg;

	// Pattern codes
	typedef enum logic [2:0] {
		PAT_UNKNOWN = 3'd0,
		PAT_OFF     = 3'd1,
		PAT_SOLID   = 3'd2,
		PAT_SLOW    = 3'd3,
		PAT_FAST    = 3'd4
	} pattern_e;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_FAST_MIN   = 3'd0,
		CFG_FAST_MAX   = 3'd1,
		CFG_SLOW_MIN   = 3'd2,
		CFG_SLOW_MAX   = 3'd3,
		CFG_SOLID_QUIET = 3'd4,
		CFG_GLITCH     = 3'd5
	} cfg_idx_e;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned MS_W      = 16;
	// Thresholds in microseconds: up to (2 * 65535) * 1000 fits in 27 bits
	localparam int unsigned THR_W     = 27;

	localparam logic [THR_W-1:0] US_PER_MS = 27'd1000;

	// Register reset values
	localparam logic [CFG_W-1:0] FAST_MIN_RST    = 16'd80;
	localparam logic [CFG_W-1:0] FAST_MAX_RST    = 16'd450;
	localparam logic [CFG_W-1:0] SLOW_MIN_RST    = 16'd1500;
	localparam logic [CFG_W-1:0] SLOW_MAX_RST    = 16'd3000;
	localparam logic [CFG_W-1:0] SOLID_QUIET_RST = 16'd1500;
	localparam logic [CFG_W-1:0] GLITCH_RST      = 16'd3000;
	localparam logic [CFG_W-1:0] MS_SAT          = 16'hFFFF;

	// floor(x / 1000) = ((x >> 3) * RECIP) >> RECIP_SHIFT, exact for 29-bit x >> 3
	localparam int unsigned          RECIP_W     = 30;
	localparam logic [RECIP_W-1:0]   RECIP       = 30'd549755814;
	localparam int unsigned          RECIP_SHIFT = 36;
	localparam int unsigned          PROD_W      = 59;

	typedef struct packed {
		logic              action;
		logic [TIME_W-1:0] time_us;
		logic              level;
	} item_t;

	typedef struct packed {
		logic            edge_accepted;
		logic [MS_W-1:0] held_ms;
		logic            held_was_on;
		logic            period_valid;
		logic [MS_W-1:0] period_ms;
		logic            period_from_on;
		pattern_e        pattern;
		logic            pattern_changed;
	} result_t;

	// Config thresholds, all in microseconds
	typedef struct packed {
		logic [CFG_W-1:0] min_gap_us;
		logic [THR_W-1:0] fast_lo_us;
		logic [THR_W-1:0] fast_hi_us;
		logic             fast_top;
		logic [THR_W-1:0] slow_lo_us;
		logic [THR_W-1:0] slow_hi_us;
		logic             slow_top;
		logic [THR_W-1:0] quiet_solid_us;
		logic [THR_W-1:0] quiet_blink_us;
	} cfg_thr_t;

	// Stage 2 contents: flags and raw microsecond spans
	typedef struct packed {
		logic              acc;
		logic              held_on;
		logic              pv;
		logic              from_on;
		pattern_e          pattern;
		logic              changed;
		logic [TIME_W-1:0] held_us;
		logic [TIME_W-1:0] per_us;
	} track_t;

endpackage

### sv/lbpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lbpc_cfg_regs: configuration registers
// Holds the six window registers and turns them into microsecond thresholds.
// ----------------------------------------------------------------------------
module lbpc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [lbpc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [lbpc_pkg::CFG_W-1:0]     cfg_wdata,
	output lbpc_pkg::cfg_thr_t             thr
);

	logic [lbpc_pkg::CFG_W-1:0] fast_min_q, fast_max_q, slow_min_q, slow_max_q;
	logic [lbpc_pkg::CFG_W-1:0] solid_quiet_q, glitch_q;

	// Decode writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_min_q    <= lbpc_pkg::FAST_MIN_RST;
			fast_max_q    <= lbpc_pkg::FAST_MAX_RST;
			slow_min_q    <= lbpc_pkg::SLOW_MIN_RST;
			slow_max_q    <= lbpc_pkg::SLOW_MAX_RST;
			solid_quiet_q <= lbpc_pkg::SOLID_QUIET_RST;
			glitch_q      <= lbpc_pkg::GLITCH_RST;
		end else if (cfg_wen) begin
			unique case (lbpc_pkg::cfg_idx_e'(cfg_idx))
				lbpc_pkg::CFG_FAST_MIN:    fast_min_q    <= cfg_wdata;
				lbpc_pkg::CFG_FAST_MAX:    fast_max_q    <= cfg_wdata;
				lbpc_pkg::CFG_SLOW_MIN:    slow_min_q    <= cfg_wdata;
				lbpc_pkg::CFG_SLOW_MAX:    slow_max_q    <= cfg_wdata;
				lbpc_pkg::CFG_SOLID_QUIET: solid_quiet_q <= cfg_wdata;
				lbpc_pkg::CFG_GLITCH:      glitch_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Scale millisecond limits to microseconds; upper bounds are exclusive (max + 1)
	always_comb begin
		thr.min_gap_us = glitch_q;
		thr.fast_lo_us = lbpc_pkg::THR_W'(fast_min_q) * lbpc_pkg::US_PER_MS;
		thr.fast_hi_us = (lbpc_pkg::THR_W'(fast_max_q) + lbpc_pkg::THR_W'(1))
			* lbpc_pkg::US_PER_MS;
		thr.fast_top   = (fast_max_q == lbpc_pkg::MS_SAT);
		thr.slow_lo_us = lbpc_pkg::THR_W'(slow_min_q) * lbpc_pkg::US_PER_MS;
		thr.slow_hi_us = (lbpc_pkg::THR_W'(slow_max_q) + lbpc_pkg::THR_W'(1))
			* lbpc_pkg::US_PER_MS;
		thr.slow_top   = (slow_max_q == lbpc_pkg::MS_SAT);
		thr.quiet_solid_us = lbpc_pkg::THR_W'(solid_quiet_q) * lbpc_pkg::US_PER_MS;
		thr.quiet_blink_us = (lbpc_pkg::THR_W'(solid_quiet_q)
			+ lbpc_pkg::THR_W'(slow_max_q)) * lbpc_pkg::US_PER_MS;
	end

endmodule

### sv/lbpc_track.sv
// ----------------------------------------------------------------------------
// lbpc_track: edge tracking and pattern state
// Applies the glitch filter, updates edge history and pattern, and registers
// the flags and raw spans of each item into stage 2.
// ----------------------------------------------------------------------------
module lbpc_track (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  lbpc_pkg::item_t    item_s1,
	input  lbpc_pkg::cfg_thr_t thr,
	output lbpc_pkg::track_t   trk_s2
);

	logic [lbpc_pkg::TIME_W-1:0] last_acc_q, prev_edge_q, last_on_q, last_off_q;
	logic                        prev_level_q, on_valid_q, off_valid_q;
	lbpc_pkg::pattern_e          pat_q;

	logic [lbpc_pkg::TIME_W-1:0] since_acc, per_raw, quiet_lim;
	logic                        accept, in_fast, in_slow, blink;
	lbpc_pkg::track_t            trk;

	// Spans and window tests
	always_comb begin
		since_acc = item_s1.time_us - last_acc_q;
		accept    = !item_s1.action && (since_acc >= lbpc_pkg::TIME_W'(thr.min_gap_us));
		per_raw   = item_s1.time_us - (item_s1.level ? last_off_q : last_on_q);
		in_fast   = (per_raw >= lbpc_pkg::TIME_W'(thr.fast_lo_us))
			&& ((per_raw < lbpc_pkg::TIME_W'(thr.fast_hi_us)) || thr.fast_top);
		in_slow   = (per_raw >= lbpc_pkg::TIME_W'(thr.slow_lo_us))
			&& ((per_raw < lbpc_pkg::TIME_W'(thr.slow_hi_us)) || thr.slow_top);
		blink     = (pat_q == lbpc_pkg::PAT_SLOW) || (pat_q == lbpc_pkg::PAT_FAST);
		quiet_lim = blink ? lbpc_pkg::TIME_W'(thr.quiet_blink_us)
			: lbpc_pkg::TIME_W'(thr.quiet_solid_us);
	end

	// Build the result flags and the next pattern
	always_comb begin
		trk         = '0;
		trk.pattern = pat_q;
		if (!item_s1.action) begin
			if (accept) begin
				trk.acc     = 1'b1;
				trk.held_us = item_s1.time_us - prev_edge_q;
				trk.held_on = !prev_level_q;
				trk.from_on = !item_s1.level;
				trk.pv      = item_s1.level ? off_valid_q : on_valid_q;
				if (trk.pv) begin
					trk.per_us = per_raw;
					if (in_fast) begin
						trk.pattern = lbpc_pkg::PAT_FAST;
					end else if (in_slow) begin
						trk.pattern = lbpc_pkg::PAT_SLOW;
					end
				end
			end
		end else if (since_acc >= quiet_lim) begin
			trk.pattern = item_s1.level ? lbpc_pkg::PAT_OFF : lbpc_pkg::PAT_SOLID;
		end
		trk.changed = (trk.pattern != pat_q);
	end

	// Update history on each item that leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_acc_q   <= '0;
			prev_edge_q  <= '0;
			prev_level_q <= 1'b1;
			last_on_q    <= '0;
			last_off_q   <= '0;
			on_valid_q   <= 1'b0;
			off_valid_q  <= 1'b0;
			pat_q        <= lbpc_pkg::PAT_UNKNOWN;
		end else if (adv) begin
			pat_q <= trk.pattern;
			if (accept) begin
				last_acc_q   <= item_s1.time_us;
				prev_edge_q  <= item_s1.time_us;
				prev_level_q <= item_s1.level;
				if (item_s1.level) begin
					last_off_q  <= item_s1.time_us;
					off_valid_q <= 1'b1;
				end else begin
					last_on_q  <= item_s1.time_us;
					on_valid_q <= 1'b1;
				end
			end
		end
	end

	// Stage 2 register
	always_ff @(posedge clk) begin
		if (adv) begin
			trk_s2 <= trk;
		end
	end

endmodule

### sv/lbpc_ms_div.sv
// ----------------------------------------------------------------------------
// lbpc_ms_div: microsecond to millisecond conversion
// Divides two spans by 1000 with a registered reciprocal multiply, then
// saturates the quotients to 16 bits.
// ----------------------------------------------------------------------------
module lbpc_ms_div (
	input  logic                        clk,
	input  logic                        adv,
	input  logic [lbpc_pkg::TIME_W-1:0] held_us,
	input  logic [lbpc_pkg::TIME_W-1:0] per_us,
	output logic [lbpc_pkg::MS_W-1:0]   held_ms,
	output logic [lbpc_pkg::MS_W-1:0]   per_ms
);

	localparam int unsigned Q_W = lbpc_pkg::PROD_W - lbpc_pkg::RECIP_SHIFT;

	logic [lbpc_pkg::PROD_W-1:0] held_prod_s3, per_prod_s3;
	logic [Q_W-1:0]              held_quo, per_quo;

	// Multiply by the reciprocal of 125 after dropping the factor of 8
	always_ff @(posedge clk) begin
		if (adv) begin
			held_prod_s3 <= lbpc_pkg::PROD_W'(held_us[lbpc_pkg::TIME_W-1:3])
				* lbpc_pkg::PROD_W'(lbpc_pkg::RECIP);
			per_prod_s3  <= lbpc_pkg::PROD_W'(per_us[lbpc_pkg::TIME_W-1:3])
				* lbpc_pkg::PROD_W'(lbpc_pkg::RECIP);
		end
	end

	// Take the quotient and clamp
	always_comb begin
		held_quo = held_prod_s3[lbpc_pkg::PROD_W-1:lbpc_pkg::RECIP_SHIFT];
		per_quo  = per_prod_s3[lbpc_pkg::PROD_W-1:lbpc_pkg::RECIP_SHIFT];
		held_ms  = (|held_quo[Q_W-1:lbpc_pkg::MS_W]) ? lbpc_pkg::MS_SAT
			: held_quo[lbpc_pkg::MS_W-1:0];
		per_ms   = (|per_quo[Q_W-1:lbpc_pkg::MS_W]) ? lbpc_pkg::MS_SAT
			: per_quo[lbpc_pkg::MS_W-1:0];
	end

endmodule

### sv/led_blink_pattern_classifier.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_classifier: LED blink pattern classifier
// Four-register pipeline: input, state update, reciprocal multiply, result.
// ----------------------------------------------------------------------------
// Path: an accepted request passes the input, stage 2, stage 3 and result registers.
// Throughput: one request per cycle while result_ready does not stall; the edge
// history and pattern update in stage 1, and the divide by 1000 is a pipelined multiply.
// Reset: arst_n clears pipeline valids, edge history and pattern at once and
// loads the register defaults; no clearing pass.
module led_blink_pattern_classifier (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  lbpc_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output lbpc_pkg::result_t              result,
	input  logic                           cfg_wen,
	input  logic [lbpc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [lbpc_pkg::CFG_W-1:0]     cfg_wdata
);

	lbpc_pkg::cfg_thr_t thr;
	lbpc_pkg::item_t    item_s1;
	lbpc_pkg::track_t   trk_s2, trk_s3;
	logic               v1_q, v2_q, v3_q;
	logic               rdy_out, rdy3, rdy2, take, adv1, adv2, adv3;
	logic [lbpc_pkg::MS_W-1:0] held_ms, per_ms;

	// Stage handshakes
	always_comb begin
		rdy_out    = !result_valid || result_ready;
		rdy3       = !v3_q || rdy_out;
		rdy2       = !v2_q || rdy3;
		item_ready = !v1_q || rdy2;
		take       = item_valid && item_ready;
		adv1       = v1_q && rdy2;
		adv2       = v2_q && rdy3;
		adv3       = v3_q && rdy_out;
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q         <= 1'b0;
			v2_q         <= 1'b0;
			v3_q         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			v1_q         <= take || (v1_q && !adv1);
			v2_q         <= adv1 || (v2_q && !adv2);
			v3_q         <= adv2 || (v3_q && !adv3);
			result_valid <= adv3 || (result_valid && !result_ready);
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	lbpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.thr       (thr)
	);

	lbpc_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv1),
		.item_s1 (item_s1),
		.thr     (thr),
		.trk_s2  (trk_s2)
	);

	lbpc_ms_div u_div (
		.clk     (clk),
		.adv     (adv2),
		.held_us (trk_s2.held_us),
		.per_us  (trk_s2.per_us),
		.held_ms (held_ms),
		.per_ms  (per_ms)
	);

	// Carry flags alongside the products
	always_ff @(posedge clk) begin
		if (adv2) begin
			trk_s3 <= trk_s2;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv3) begin
			result.edge_accepted   <= trk_s3.acc;
			result.held_ms         <= held_ms;
			result.held_was_on     <= trk_s3.held_on;
			result.period_valid    <= trk_s3.pv;
			result.period_ms       <= per_ms;
			result.period_from_on  <= trk_s3.from_on;
			result.pattern         <= trk_s3.pattern;
			result.pattern_changed <= trk_s3.changed;
		end
	end

	// An accepted request always lands in stage 1
	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> v1_q)
		else $error("accepted request did not reach stage 1");

	// A period is only reported for an accepted edge
	a_period_needs_edge: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.period_valid || result.edge_accepted))
		else $error("period reported without accepted edge");

	// Polls and rejected edges carry zero spans
	a_zero_spans: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.edge_accepted)
		|-> (result.held_ms == '0 && result.period_ms == '0))
		else $error("nonzero span without accepted edge");

endmodule

### bench/led_blink_pattern_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_pattern_classifier_test: self-checking bench for the classifier
// Drives edge and poll requests through the valid/ready input and predicts
// every result with a cycle-free model of the edge history and pattern state.
// It walks through several register settings and checks each result field.
// ----------------------------------------------------------------------------
module led_blink_pattern_classifier_test;

	localparam logic ACT_EDGE = 1'b0;
	localparam logic ACT_POLL = 1'b1;
	localparam logic LVL_ON   = 1'b0;
	localparam logic LVL_OFF  = 1'b1;

	localparam int PHASE_ITEMS  = 275;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 6;
	localparam int MAX_REPORTS  = 10;

	// Predictor of the classifier plus the queue of results it expects
	class blink_scoreboard;
		logic [lbpc_pkg::CFG_W-1:0]  fast_min, fast_max, slow_min, slow_max;
		logic [lbpc_pkg::CFG_W-1:0]  solid_quiet, glitch;
		logic [lbpc_pkg::TIME_W-1:0] last_accepted, prev_edge, last_on, last_off;
		logic                        prev_level, on_seen, off_seen;
		lbpc_pkg::pattern_e          cur_pattern, shown_pattern;
		lbpc_pkg::result_t           pending[$];
		int                          mismatches;

		function new();
			fast_min      = lbpc_pkg::FAST_MIN_RST;
			fast_max      = lbpc_pkg::FAST_MAX_RST;
			slow_min      = lbpc_pkg::SLOW_MIN_RST;
			slow_max      = lbpc_pkg::SLOW_MAX_RST;
			solid_quiet   = lbpc_pkg::SOLID_QUIET_RST;
			glitch        = lbpc_pkg::GLITCH_RST;
			last_accepted = '0;
			prev_edge     = '0;
			last_on       = '0;
			last_off      = '0;
			prev_level    = LVL_OFF;
			on_seen       = 1'b0;
			off_seen      = 1'b0;
			cur_pattern   = lbpc_pkg::PAT_UNKNOWN;
			shown_pattern = lbpc_pkg::PAT_UNKNOWN;
			mismatches    = 0;
		endfunction

		function void set_reg(lbpc_pkg::cfg_idx_e idx, logic [lbpc_pkg::CFG_W-1:0] value);
			case (idx)
				lbpc_pkg::CFG_FAST_MIN:    fast_min = value;
				lbpc_pkg::CFG_FAST_MAX:    fast_max = value;
				lbpc_pkg::CFG_SLOW_MIN:    slow_min = value;
				lbpc_pkg::CFG_SLOW_MAX:    slow_max = value;
				lbpc_pkg::CFG_SOLID_QUIET: solid_quiet = value;
				lbpc_pkg::CFG_GLITCH:      glitch = value;
				default: ;
			endcase
		endfunction

		// Convert a microsecond span to saturated milliseconds
		function logic [lbpc_pkg::MS_W-1:0] to_ms(logic [lbpc_pkg::TIME_W-1:0] span_us);
			logic [lbpc_pkg::TIME_W-1:0] q;
			q = span_us / lbpc_pkg::US_PER_MS;
			return (q > {16'd0, lbpc_pkg::MS_SAT}) ? lbpc_pkg::MS_SAT
				: q[lbpc_pkg::MS_W-1:0];
		endfunction

		// Compute the expected result of one accepted request
		function void note_request(lbpc_pkg::item_t req);
			lbpc_pkg::result_t           exp;
			logic [lbpc_pkg::TIME_W-1:0] idle_ms;
			logic [16:0]                 limit_ms;
			logic                        blinking;
			exp = '0;
			if (req.action == ACT_EDGE) begin
				if ((req.time_us - last_accepted) >= {16'd0, glitch}) begin
					exp.edge_accepted  = 1'b1;
					last_accepted      = req.time_us;
					exp.held_ms        = to_ms(req.time_us - prev_edge);
					exp.held_was_on    = (prev_level == LVL_ON);
					prev_edge          = req.time_us;
					prev_level         = req.level;
					exp.period_from_on = (req.level == LVL_ON);
					if (exp.period_from_on) begin
						if (on_seen) begin
							exp.period_valid = 1'b1;
							exp.period_ms    = to_ms(req.time_us - last_on);
						end
						last_on = req.time_us;
						on_seen = 1'b1;
					end else begin
						if (off_seen) begin
							exp.period_valid = 1'b1;
							exp.period_ms    = to_ms(req.time_us - last_off);
						end
						last_off = req.time_us;
						off_seen = 1'b1;
					end
					// Fast window wins over slow; a period outside both keeps the pattern
					if (exp.period_valid) begin
						if (exp.period_ms >= fast_min && exp.period_ms <= fast_max)
							cur_pattern = lbpc_pkg::PAT_FAST;
						else if (exp.period_ms >= slow_min && exp.period_ms <= slow_max)
							cur_pattern = lbpc_pkg::PAT_SLOW;
					end
				end
			end else begin
				idle_ms  = (req.time_us - last_accepted) / lbpc_pkg::US_PER_MS;
				blinking = (cur_pattern == lbpc_pkg::PAT_SLOW)
					|| (cur_pattern == lbpc_pkg::PAT_FAST);
				limit_ms = blinking ? ({1'b0, solid_quiet} + {1'b0, slow_max})
				                    : {1'b0, solid_quiet};
				if (idle_ms >= limit_ms)
					cur_pattern = (req.level == LVL_ON) ? lbpc_pkg::PAT_SOLID
						: lbpc_pkg::PAT_OFF;
			end
			exp.pattern         = cur_pattern;
			exp.pattern_changed = (cur_pattern != shown_pattern);
			shown_pattern       = cur_pattern;
			pending.push_back(exp);
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(lbpc_pkg::result_t got);
			lbpc_pkg::result_t exp;
			logic              bad;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result at %0t: pattern=%0d", $realtime, got.pattern);
				return;
			end
			exp = pending.pop_front();
			bad = (got.edge_accepted !== exp.edge_accepted)
			   || (got.held_ms !== exp.held_ms)
			   || (got.held_was_on !== exp.held_was_on)
			   || (got.period_valid !== exp.period_valid)
			   || (got.period_ms !== exp.period_ms)
			   || (got.period_from_on !== exp.period_from_on)
			   || (got.pattern !== exp.pattern)
			   || (got.pattern_changed !== exp.pattern_changed);
			if (bad) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("mismatch at %0t: exp acc=%0d held=%0d on=%0d pv=%0d",
						$realtime, exp.edge_accepted, exp.held_ms, exp.held_was_on,
						exp.period_valid);
					$display("    exp per=%0d fon=%0d pat=%0d chg=%0d",
						exp.period_ms, exp.period_from_on,
						exp.pattern, exp.pattern_changed);
					$display("    got acc=%0d held=%0d on=%0d pv=%0d",
						got.edge_accepted, got.held_ms, got.held_was_on,
						got.period_valid);
					$display("    got per=%0d fon=%0d pat=%0d chg=%0d",
						got.period_ms, got.period_from_on,
						got.pattern, got.pattern_changed);
				end
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           item_valid = 1'b0;
	logic                           item_ready;
	lbpc_pkg::item_t                item = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	lbpc_pkg::result_t              result;
	logic                           cfg_wen = 1'b0;
	logic [lbpc_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [lbpc_pkg::CFG_W-1:0]     cfg_wdata = '0;

	blink_scoreboard sb = new();

	// Random idling control and the receiver hold-off request
	bit steady_run = 1'b0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	// Blink generator state
	logic [lbpc_pkg::TIME_W-1:0] gen_now = '0;
	logic                        gen_level = LVL_OFF;
	int unsigned                 burst_left = 0;
	int unsigned                 target_ms = 500;

	led_blink_pattern_classifier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit take_break();
		return !steady_run && ($urandom_range(0, 99) < 36);
	endfunction

	function automatic lbpc_pkg::item_t make_request(logic act,
			logic [lbpc_pkg::TIME_W-1:0] t, logic lvl);
		lbpc_pkg::item_t req;
		req.action  = act;
		req.time_us = t;
		req.level   = lvl;
		return req;
	endfunction

	// Pick the next random request: mostly blink trains, some polls, glitches, noise
	function automatic lbpc_pkg::item_t next_request();
		int unsigned                 pick, base_ms, q_ms;
		logic [lbpc_pkg::TIME_W-1:0] t;
		lbpc_pkg::item_t             req;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			req = make_request(1'($urandom_range(0, 1)), $urandom,
				1'($urandom_range(0, 1)));
		end else if (pick < 20) begin
			t = gen_now + $urandom_range(0, sb.glitch);
			gen_now = t;
			req = make_request(ACT_EDGE, t, 1'($urandom_range(0, 1)));
		end else if (pick < 36) begin
			case ($urandom_range(0, 2))
				0: base_ms = 32'(sb.solid_quiet);
				1: base_ms = 32'(sb.solid_quiet) + 32'(sb.slow_max);
				default: base_ms = $urandom_range(0, 2 * (sb.solid_quiet + sb.slow_max) + 2);
			endcase
			q_ms = base_ms + $urandom_range(0, 2);
			q_ms = (q_ms > 0) ? q_ms - 1 : 0;
			t = gen_now + q_ms * 1000 + $urandom_range(0, 999);
			if ($urandom_range(0, 1))
				gen_now = t;
			req = make_request(ACT_POLL, t, 1'($urandom_range(0, 1)));
		end else begin
			// Start a new train with a fresh target period
			if (burst_left == 0) begin
				case ($urandom_range(0, 3))
					0: target_ms = $urandom_range(sb.fast_min, sb.fast_max);
					1: target_ms = $urandom_range(sb.slow_min, sb.slow_max);
					2: target_ms = $urandom_range(0, 70000);
					default: begin
						case ($urandom_range(0, 3))
							0: target_ms = 32'(sb.fast_min);
							1: target_ms = 32'(sb.fast_max);
							2: target_ms = 32'(sb.slow_min);
							default: target_ms = 32'(sb.slow_max);
						endcase
						target_ms = target_ms + $urandom_range(0, 2);
						target_ms = (target_ms > 0) ? target_ms - 1 : 0;
					end
				endcase
				burst_left = $urandom_range(4, 24);
			end
			burst_left--;
			gen_level = ~gen_level;
			gen_now = gen_now + target_ms * 500 + $urandom_range(0, 499);
			req = make_request(ACT_EDGE, gen_now, gen_level);
		end
		return req;
	endfunction

	// Offer one request and hold it until accepted; valid stays up for the next one
	task automatic send_request(lbpc_pkg::item_t req);
		while (take_break()) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.note_request(req);
	endtask

	task automatic write_reg(lbpc_pkg::cfg_idx_e idx, logic [lbpc_pkg::CFG_W-1:0] value);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic apply_settings(logic [lbpc_pkg::CFG_W-1:0] f_lo,
			logic [lbpc_pkg::CFG_W-1:0] f_hi,
			logic [lbpc_pkg::CFG_W-1:0] s_lo, logic [lbpc_pkg::CFG_W-1:0] s_hi,
			logic [lbpc_pkg::CFG_W-1:0] quiet, logic [lbpc_pkg::CFG_W-1:0] gl);
		write_reg(lbpc_pkg::CFG_FAST_MIN, f_lo);
		write_reg(lbpc_pkg::CFG_FAST_MAX, f_hi);
		write_reg(lbpc_pkg::CFG_SLOW_MIN, s_lo);
		write_reg(lbpc_pkg::CFG_SLOW_MAX, s_hi);
		write_reg(lbpc_pkg::CFG_SOLID_QUIET, quiet);
		write_reg(lbpc_pkg::CFG_GLITCH, gl);
		cfg_wen <= 1'b0;
	endtask

	// Wait for every expected result, then let the pipeline settle
	task automatic wait_drained();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(int count, int hold_at);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_request = 1'b1;
			send_request(next_request());
		end
		item_valid <= 1'b0;
	endtask

	// Directed requests under reset settings
	task automatic run_directed();
		logic [lbpc_pkg::TIME_W-1:0] t0;
		t0 = 32'd5283000;
		send_request(make_request(ACT_EDGE, 32'd0, LVL_ON));          // same time as reset: glitch
		send_request(make_request(ACT_EDGE, 32'd2999, LVL_ON));       // one under glitch time
		send_request(make_request(ACT_POLL, 32'd1000, LVL_OFF));      // short quiet
		send_request(make_request(ACT_EDGE, 32'd3000, LVL_ON));       // first edge, no period
		send_request(make_request(ACT_EDGE, 32'd253000, LVL_OFF));
		send_request(make_request(ACT_EDGE, 32'd503000, LVL_ON));     // period outside windows
		send_request(make_request(ACT_EDGE, 32'd703000, LVL_OFF));    // fast at top edge
		send_request(make_request(ACT_EDGE, 32'd704000, LVL_ON));     // glitch
		send_request(make_request(ACT_EDGE, 32'd783000, LVL_ON));     // same level twice
		send_request(make_request(ACT_POLL, 32'd783000 + 32'd4499999, LVL_OFF)); // under blink limit
		send_request(make_request(ACT_POLL, 32'd783000 + 32'd4500000, LVL_OFF)); // off
		send_request(make_request(ACT_EDGE, t0, LVL_OFF));
		send_request(make_request(ACT_EDGE, t0 + 32'd1000000, LVL_ON));
		send_request(make_request(ACT_EDGE, t0 + 32'd1500000, LVL_OFF)); // slow at bottom edge
		send_request(make_request(ACT_EDGE, t0 + 32'd3000000, LVL_ON));
		send_request(make_request(ACT_POLL, t0 + 32'd7500000, LVL_ON));  // solid
		send_request(make_request(ACT_EDGE, 32'hFFFFF000, LVL_OFF));     // saturated spans
		send_request(make_request(ACT_EDGE, 32'd2000, LVL_ON));          // wrap of the clock
		send_request(make_request(ACT_EDGE, 32'hFFFFFFFF, LVL_OFF));
		send_request(make_request(ACT_POLL, 32'hFFFFFFFF, LVL_ON));
		send_request(make_request(ACT_EDGE, 32'h7FFFFFFF, LVL_OFF));
		item_valid <= 1'b0;
	endtask

	// Receiver: check accepted results, stall at random, honor a long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				sb.check_result(result);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= !take_break();
			end
		end
	end

	// Main sequence: reset, directed part, then random phases over several settings
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_drained();

		apply_settings(16'($urandom_range(0, 300)), 16'($urandom_range(300, 1000)),
			16'($urandom_range(1000, 3000)), 16'($urandom_range(3000, 6000)),
			16'($urandom_range(0, 5000)), 16'($urandom_range(0, 65535)));
		run_random(PHASE_ITEMS, 40);
		wait_drained();

		apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_random(PHASE_ITEMS, -1);
		wait_drained();

		apply_settings(lbpc_pkg::MS_SAT, lbpc_pkg::MS_SAT, lbpc_pkg::MS_SAT,
			lbpc_pkg::MS_SAT, lbpc_pkg::MS_SAT, lbpc_pkg::MS_SAT);
		run_random(PHASE_ITEMS, -1);
		wait_drained();

		// Overlapping windows: fast is tested first
		apply_settings(16'd100, 16'd2000, 16'd1500, 16'd2500, 16'd800, 16'd0);
		run_random(PHASE_ITEMS, -1);
		wait_drained();

		// Inverted windows with no idling on either side
		steady_run = 1'b1;
		apply_settings(16'd500, 16'd100, 16'd4000, 16'd1000, 16'd2000, 16'd1);
		run_random(PHASE_ITEMS, -1);
		wait_drained();
		steady_run = 1'b0;

		apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		run_random(PHASE_ITEMS, -1);
		wait_drained();

		apply_settings(lbpc_pkg::FAST_MIN_RST, lbpc_pkg::FAST_MAX_RST,
			lbpc_pkg::SLOW_MIN_RST, lbpc_pkg::SLOW_MAX_RST,
			lbpc_pkg::SOLID_QUIET_RST, lbpc_pkg::GLITCH_RST);
		run_random(PHASE_ITEMS, -1);
		wait_drained();

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Stop a hung run
	initial begin
		#3000000;
		$display("Verification failed");
		$finish;
	end

endmodule
